[sv/dlt_pkg.sv]
// ----------------------------------------------------------------------------
// dlt_pkg - shared types, constants and table functions
// Constants of the double log pipeline, the result class codes, the stage
// enable group and the elaboration-time builder of the midpoint log table.
// ----------------------------------------------------------------------------
package dlt_pkg;

	localparam int TABLE_INDEX_BITS_DEF = 12;
	localparam int EXP_BIAS = 1023;

	localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
	// 1e308 as a double; positive doubles order like their bit patterns
	localparam logic [63:0] BIG_LIMIT    = 64'h7FE1_CCF3_85EB_C8A0;

	// ln2 as a 53-bit integer mantissa: ln2 = LN2_MANT * 2^-53
	localparam logic [52:0] LN2_MANT = 53'h1_62E4_2FEF_A39EF;

	typedef enum logic [1:0] {
		CLS_NORMAL  = 2'd0,
		CLS_NAN     = 2'd1,
		CLS_NEG_INF = 2'd2,
		CLS_POS_INF = 2'd3
	} cls_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Item data that rides alongside the arithmetic
	typedef struct packed {
		cls_t        cls;
		logic        m1_zero;
		logic        m1_neg;
		logic [31:0] rom;
	} side_t;

	// Single-precision log of bucket midpoint 1 + (2i+1)/2^(bits+1)
	function automatic logic [31:0] rom_entry(input int i, input int bits);
		real         f;
		real         r;
		logic [63:0] d;
		logic [23:0] m;
		logic [7:0]  e8;
		logic        inc;
		f = real'(2 * i + 1);
		for (int k = 0; k <= bits; k++) begin
			f = f * 0.5;
		end
		r = $ln(1.0 + f);
		d = $realtobits(r);
		inc = d[28] & ((|d[27:0]) | d[29]);
		m = {1'b0, d[51:29]} + 24'(inc);
		e8 = 8'(d[62:52] - 11'd896);
		if (m[23]) begin
			e8 = e8 + 8'd1;
		end
		return {1'b0, e8, m[22:0]};
	endfunction

	// Exact widening of a normal single to a double
	function automatic logic [63:0] rom_to_double(input logic [31:0] f);
		return {f[31], {3'b000, f[30:23]} + 11'd896, f[22:0], 29'd0};
	endfunction

endpackage

[sv/double_log_table_approx.sv]
// ----------------------------------------------------------------------------
// double_log_table_approx - table-driven natural log of a double
// Six-stage pipeline: table read, multiply, round, add, leading one, round.
// ----------------------------------------------------------------------------
// Each request carries the raw bits of one IEEE double and yields one result:
// ln2 * (exponent - 1023) rounded to double, plus a table entry picked by the
// top TABLE_INDEX_BITS mantissa bits (single-precision log of the bucket
// midpoint), the sum rounded to nearest even. NaN and negative inputs give a
// quiet NaN (class 1), zero gives minus infinity (class 2), and anything above
// 1e308, infinity included, gives plus infinity (class 3); denormals go
// through as exponent -1023 with no normalization. The pipeline takes one
// request per clock while the output is not stalled; the result passes
// through the six register stages and is valid once the last one holds it.
// Every stage holds its own valid bit, so a stall at the output only
// freezes the stages that are full and bubbles are squeezed out. The table is
// a constant ROM of 2^TABLE_INDEX_BITS entries with one registered read port,
// needs no fill after reset, and sets the first stage.
// ----------------------------------------------------------------------------
module double_log_table_approx #(
	parameter int TABLE_INDEX_BITS = dlt_pkg::TABLE_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] operand_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] log_bits,
	output logic [1:0]  special_class
);

	dlt_pkg::stage_en_t en;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	dlt_pkg::side_t     side_in;
	dlt_pkg::side_t     side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [9:0]         m1_mag_in;
	logic [9:0]         m1_mag_s1;
	logic [31:0]        rom_s1;
	logic signed [7:0]  prod_exp_s3;
	logic [52:0]        prod_mant_s3;
	logic [62:0]        mag_s6;
	logic [10:0]        expo;

	// A stage may load when it is empty or its contents move on
	always_comb begin
		en.s6 = !v_s6 || out_ready;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s6;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	// Classify the operand and split off the signed exponent
	always_comb begin
		expo = operand_bits[62:52];
		side_in.rom = '0;
		side_in.m1_neg = (expo < 11'(dlt_pkg::EXP_BIAS));
		side_in.m1_zero = (expo == 11'(dlt_pkg::EXP_BIAS));
		m1_mag_in = side_in.m1_neg ? 10'(11'(dlt_pkg::EXP_BIAS) - expo)
		                           : 10'(expo - 11'(dlt_pkg::EXP_BIAS));
		if (operand_bits[62:0] > dlt_pkg::POS_INF_BITS[62:0]) begin
			side_in.cls = dlt_pkg::CLS_NAN;
		end else if (operand_bits[62:0] == 63'd0) begin
			side_in.cls = dlt_pkg::CLS_NEG_INF;
		end else if (operand_bits[63]) begin
			side_in.cls = dlt_pkg::CLS_NAN;
		end else if (operand_bits > dlt_pkg::BIG_LIMIT) begin
			side_in.cls = dlt_pkg::CLS_POS_INF;
		end else begin
			side_in.cls = dlt_pkg::CLS_NORMAL;
		end
	end

	dlt_rom #(
		.IDX_BITS(TABLE_INDEX_BITS)
	) u_rom (
		.clk   (clk),
		.en    (en.s1),
		.addr  (operand_bits[51 -: TABLE_INDEX_BITS]),
		.rom_s1(rom_s1)
	);

	// Hold the side data in step with the arithmetic
	always_ff @(posedge clk) begin
		if (en.s1) begin
			side_s1 <= side_in;
			m1_mag_s1 <= m1_mag_in;
		end
		if (en.s2) begin
			side_s2 <= '{cls: side_s1.cls, m1_zero: side_s1.m1_zero,
			             m1_neg: side_s1.m1_neg, rom: rom_s1};
		end
		if (en.s3) side_s3 <= side_s2;
		if (en.s4) side_s4 <= side_s3;
		if (en.s5) side_s5 <= side_s4;
		if (en.s6) side_s6 <= side_s5;
	end

	dlt_mul u_mul (
		.clk         (clk),
		.en          (en),
		.m1_mag_s1   (m1_mag_s1),
		.prod_exp_s3 (prod_exp_s3),
		.prod_mant_s3(prod_mant_s3)
	);

	dlt_add u_add (
		.clk         (clk),
		.en          (en),
		.prod_exp_s3 (prod_exp_s3),
		.prod_mant_s3(prod_mant_s3),
		.rom_s3      (side_s3.rom),
		.neg_s3      (side_s3.m1_neg),
		.mag_s6      (mag_s6)
	);

	// Pick the special pattern, the bare table entry for a zero exponent,
	// or the rounded sum
	always_comb begin
		special_class = side_s6.cls;
		case (side_s6.cls)
			dlt_pkg::CLS_NAN:     log_bits = dlt_pkg::QNAN_BITS;
			dlt_pkg::CLS_NEG_INF: log_bits = dlt_pkg::NEG_INF_BITS;
			dlt_pkg::CLS_POS_INF: log_bits = dlt_pkg::POS_INF_BITS;
			default: begin
				if (side_s6.m1_zero) begin
					log_bits = dlt_pkg::rom_to_double(side_s6.rom);
				end else begin
					log_bits = {side_s6.m1_neg, mag_s6};
				end
			end
		endcase
	end

endmodule

[sv/dlt_rom.sv]
// ----------------------------------------------------------------------------
// dlt_rom - midpoint log table
// Constant table of single-precision midpoint logarithms, read through a
// registered port.
// ----------------------------------------------------------------------------
module dlt_rom #(
	parameter int IDX_BITS = dlt_pkg::TABLE_INDEX_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IDX_BITS-1:0] addr,
	output logic [31:0]         rom_s1
);

	localparam int DEPTH = 1 << IDX_BITS;

	logic [31:0] rom_w [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		localparam logic [31:0] ENTRY = dlt_pkg::rom_entry(i, IDX_BITS);
		assign rom_w[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1 <= rom_w[addr];
		end
	end

endmodule

[sv/dlt_mul.sv]
// ----------------------------------------------------------------------------
// dlt_mul - ln2 times exponent
// Multiplies ln2 by the exponent magnitude, then normalizes and rounds the
// product to a double mantissa (nearest even).
// ----------------------------------------------------------------------------
module dlt_mul (
	input  logic               clk,
	input  dlt_pkg::stage_en_t en,
	input  logic [9:0]         m1_mag_s1,
	output logic signed [7:0]  prod_exp_s3,
	output logic [52:0]        prod_mant_s3
);

	logic [62:0] prod_s2;
	logic [3:0]  lead;
	logic [62:0] norm;
	logic        inc;
	logic [53:0] rnd;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= 63'(dlt_pkg::LN2_MANT) * 63'(m1_mag_s1);
		end
	end

	// leading one sits in bits 52..62 for any nonzero magnitude
	always_comb begin
		lead = 4'd0;
		for (int k = 0; k < 11; k++) begin
			if (prod_s2[52 + k]) begin
				lead = 4'(k);
			end
		end
		norm = prod_s2 << (4'd10 - lead);
		inc = norm[9] & ((|norm[8:0]) | norm[10]);
		rnd = {1'b0, norm[62:10]} + 54'(inc);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (rnd[53]) begin
				prod_mant_s3 <= {1'b1, 52'd0};
				prod_exp_s3 <= 8'(signed'({4'd0, lead})) ;
			end else begin
				prod_mant_s3 <= rnd[52:0];
				prod_exp_s3 <= 8'(signed'({4'd0, lead})) - 8'sd1;
			end
		end
	end

endmodule

[sv/dlt_add.sv]
// ----------------------------------------------------------------------------
// dlt_add - product plus table entry
// Aligns the table entry to the product, adds or subtracts exactly, finds
// the leading one, then normalizes and rounds to a double (nearest even).
// ----------------------------------------------------------------------------
module dlt_add (
	input  logic               clk,
	input  dlt_pkg::stage_en_t en,
	input  logic signed [7:0]  prod_exp_s3,
	input  logic [52:0]        prod_mant_s3,
	input  logic [31:0]        rom_s3,
	input  logic               neg_s3,
	output logic [62:0]        mag_s6
);

	logic signed [9:0]  rom_exp;
	logic signed [9:0]  exp_diff;
	logic [6:0]         sh;
	logic [117:0]       a_ext;
	logic [117:0]       b_ext;
	logic [117:0]       r_s4;
	logic signed [7:0]  exp_s4;
	logic [117:0]       r_s5;
	logic signed [7:0]  exp_s5;
	logic [6:0]         lead_s5;
	logic [6:0]         lead;
	logic [117:0]       norm;
	logic               inc;
	logic [53:0]        rnd;
	logic signed [11:0] res_exp;

	// exact sum in units of 2^(prod_exp - 116)
	always_comb begin
		rom_exp = signed'({2'b00, rom_s3[30:23]}) - 10'sd127;
		exp_diff = 10'(prod_exp_s3) - rom_exp;
		sh = 7'(10'sd93 - exp_diff);
		a_ext = {1'b0, prod_mant_s3, 64'd0};
		b_ext = 118'({1'b1, rom_s3[22:0]}) << sh;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			r_s4 <= neg_s3 ? a_ext - b_ext : a_ext + b_ext;
			exp_s4 <= prod_exp_s3;
		end
	end

	always_comb begin
		lead = 7'd0;
		for (int k = 0; k < 118; k++) begin
			if (r_s4[k]) begin
				lead = 7'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			r_s5 <= r_s4;
			exp_s5 <= exp_s4;
			lead_s5 <= lead;
		end
	end

	always_comb begin
		norm = r_s5 << (7'd117 - lead_s5);
		inc = norm[64] & ((|norm[63:0]) | norm[65]);
		rnd = {1'b0, norm[117:65]} + 54'(inc);
		res_exp = 12'(exp_s5) + signed'({5'd0, lead_s5}) + 12'sd907 + 12'(rnd[53]);
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			mag_s6 <= {res_exp[10:0], rnd[53] ? 52'd0 : rnd[51:0]};
		end
	end

endmodule

[sv/dlt_check.sv]
// ----------------------------------------------------------------------------
// dlt_check - port checker for the double log pipeline
// Watches the result channel and the class codes against the result bits.
// ----------------------------------------------------------------------------
module dlt_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] log_bits,
	input logic [1:0]  special_class
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(log_bits))
		else $error("result dropped or changed while stalled");

	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && special_class == dlt_pkg::CLS_NAN |-> log_bits == dlt_pkg::QNAN_BITS)
		else $error("NaN class without quiet NaN");

	a_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && special_class == dlt_pkg::CLS_NEG_INF |->
		log_bits == dlt_pkg::NEG_INF_BITS)
		else $error("minus infinity class mismatch");

	a_finite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && special_class == dlt_pkg::CLS_NORMAL |-> log_bits[62:52] != 11'h7FF)
		else $error("normal class with non-finite result");

endmodule

bind double_log_table_approx dlt_check u_dlt_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.log_bits     (log_bits),
	.special_class(special_class)
);
